// ----- src/uart_pkg.sv -----
// Package for the 8N1 UART transceiver with transmit and receive ring queues.
// Holds the transaction payload types, phase enums and shared constants.
// No dependencies; compile before every other file of the block.
package uart_pkg;

    // Queue depth defaults (slots; a queue holds at most depth-1 bytes)
    localparam int TX_QUEUE_DEPTH_DEF = 64;
    localparam int RX_QUEUE_DEPTH_DEF = 64;

    // Serial framing
    localparam int DATA_BITS = 8;
    localparam logic [15:0] TX_START_DELAY = 16'd10;
    localparam logic [15:0] BIT_PERIOD_RESET = 16'd208;

    // Item kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam logic REG_BIT_PERIOD = 1'b0;

    typedef enum logic [1:0] {
        TX_IDLE  = 2'd0,
        TX_START = 2'd1,
        TX_DATA  = 2'd2,
        TX_STOP  = 2'd3
    } tx_phase_t;

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_DATA = 2'd1,
        RX_STOP = 2'd2
    } rx_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       rx_level;
    } in_item_t;

    typedef struct packed {
        logic       tx_level;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       write_accepted;
        logic [5:0] rx_count;
        logic [5:0] tx_count;
    } out_item_t;

endpackage

// ----- src/uart_8n1_transceiver_fifo_unit.sv -----
// 8N1 UART transmitter and receiver, each with a ring queue in block memory.
// Depends on uart_pkg.
//
// Usage:
// - Input channel (s_valid/s_ready/s_data) carries one transaction per item:
//   a timer tick with the sampled receive line, a byte to queue for sending,
//   or a request to take one received byte. Every item yields exactly one
//   result transaction on the output channel (m_valid/m_ready/m_data).
// - Timing: an accepted item lands in the input register, is processed once
//   the result slot is free and is registered into the result register,
//   which drives m_valid. One item per cycle is sustained while m_ready stays
//   high; the whole update is a single pass of logic between the two
//   registers, with the queue memories read into registers at that edge.
// - Stall: while a result waits for m_ready, the block still holds one more
//   item in its input register; s_ready drops only when both are full.
// - bit_period is written over the APB port at address 0 (ticks per bit);
//   write it only while no transaction is in flight.
// - Reset: both queues empty, both lines idle, tx line high, bit_period 208,
//   no result pending. Queue memories are not cleared.
module uart_8n1_transceiver_fifo_unit #(
    parameter int TX_QUEUE_DEPTH = uart_pkg::TX_QUEUE_DEPTH_DEF,
    parameter int RX_QUEUE_DEPTH = uart_pkg::RX_QUEUE_DEPTH_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  uart_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output uart_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [uart_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import uart_pkg::*;

    localparam int TX_AW = $clog2(TX_QUEUE_DEPTH);
    localparam int RX_AW = $clog2(RX_QUEUE_DEPTH);
    localparam int TX_CW = (TX_AW >= 6) ? TX_AW + 1 : 7;
    localparam int RX_CW = (RX_AW >= 6) ? RX_AW + 1 : 7;
    localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_QUEUE_DEPTH - 1);
    localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_QUEUE_DEPTH - 1);
    localparam logic [3:0] BITS_DONE = 4'(DATA_BITS);

    // Queue memories
    logic [7:0] tx_mem [TX_QUEUE_DEPTH];
    logic [7:0] rx_mem [RX_QUEUE_DEPTH];

    // Handshake registers
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_reg;
    logic      m_valid_reg, m_valid_next;
    logic      advance;

    // Result registers
    logic       tx_level_reg;
    logic       read_valid_reg, read_valid_next;
    logic       write_acc_reg, write_acc_next;
    logic [5:0] rx_cnt_reg, rx_cnt_next;
    logic [5:0] tx_cnt_reg, tx_cnt_next;
    logic [7:0] rd_byte_reg;

    // Configuration
    logic [15:0] bit_period_reg;
    logic        cfg_wr;

    // Transmit state
    logic [TX_AW-1:0] tx_head_reg, tx_head_next;
    logic [TX_AW-1:0] tx_tail_reg, tx_tail_next;
    tx_phase_t        tx_phase_reg, tx_phase_next;
    logic [3:0]       tx_bits_reg, tx_bits_next;
    logic [7:0]       tx_shift_reg;
    logic [15:0]      tx_cd_reg, tx_cd_next;
    logic             tx_timer_reg, tx_timer_next;
    logic             tx_out_reg, tx_out_next;
    logic             tx_wr, tx_load, tx_full, tx_empty;
    logic [TX_AW-1:0] tx_head_inc, tx_tail_inc;

    // Receive state
    logic [RX_AW-1:0] rx_head_reg, rx_head_next;
    logic [RX_AW-1:0] rx_tail_reg, rx_tail_next;
    rx_phase_t        rx_phase_reg, rx_phase_next;
    logic [3:0]       rx_bits_reg, rx_bits_next;
    logic [7:0]       rx_shift_reg, rx_shift_next;
    logic [16:0]      rx_cd_reg, rx_cd_next;
    logic             rx_timer_reg, rx_timer_next;
    logic             rx_last_reg, rx_last_next;
    logic             rx_wr, rx_rd, rx_full, rx_empty;
    logic [RX_AW-1:0] rx_head_inc, rx_tail_inc;

    logic [TX_CW-1:0] tx_count;
    logic [RX_CW-1:0] rx_count;

    // Handshake: the input register drains whenever the result slot frees up
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BIT_PERIOD);
    assign prdata = (paddr[2] == REG_BIT_PERIOD) ? {16'd0, bit_period_reg} : 32'd0;

    // Queue pointer helpers
    assign tx_head_inc = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + 1'b1;
    assign rx_head_inc = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + 1'b1;
    assign tx_full  = (tx_head_inc == tx_tail_reg);
    assign tx_empty = (tx_head_reg == tx_tail_reg);
    assign rx_full  = (rx_head_inc == rx_tail_reg);
    assign rx_empty = (rx_head_reg == rx_tail_reg);

    // Transmit next state: timer, frame sequencer, queue write and queue read
    always_comb begin
        tx_head_next  = tx_head_reg;
        tx_tail_next  = tx_tail_reg;
        tx_phase_next = tx_phase_reg;
        tx_bits_next  = tx_bits_reg;
        tx_cd_next    = tx_cd_reg;
        tx_timer_next = tx_timer_reg;
        tx_out_next   = tx_out_reg;
        tx_wr         = 1'b0;
        tx_load       = 1'b0;
        if (advance) begin
            unique case (in_reg.kind)
                KIND_TICK: begin
                    if (tx_timer_reg) begin
                        if (tx_cd_reg <= 16'd1) begin
                            tx_cd_next = bit_period_reg;
                            unique case (tx_phase_reg)
                                TX_START: begin
                                    if (tx_empty) begin
                                        tx_phase_next = TX_IDLE;
                                        tx_timer_next = 1'b0;
                                    end else begin
                                        tx_out_next   = 1'b0;
                                        tx_load       = 1'b1;
                                        tx_tail_next  = tx_tail_inc;
                                        tx_bits_next  = '0;
                                        tx_phase_next = TX_DATA;
                                    end
                                end
                                TX_DATA: begin
                                    tx_out_next  = tx_shift_reg[tx_bits_reg[2:0]];
                                    tx_bits_next = tx_bits_reg + 4'd1;
                                    if (tx_bits_next >= BITS_DONE) begin
                                        tx_phase_next = TX_STOP;
                                    end
                                end
                                TX_STOP: begin
                                    tx_out_next   = 1'b1;
                                    tx_phase_next = TX_IDLE;
                                end
                                TX_IDLE: begin
                                    if (!tx_empty) begin
                                        tx_phase_next = TX_START;
                                    end else begin
                                        tx_timer_next = 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end else begin
                            tx_cd_next = tx_cd_reg - 16'd1;
                        end
                    end
                end
                KIND_WRITE: begin
                    if (!tx_full) begin
                        tx_wr        = 1'b1;
                        tx_head_next = tx_head_inc;
                        if (tx_phase_reg == TX_IDLE) begin
                            tx_phase_next = TX_START;
                            tx_cd_next    = TX_START_DELAY;
                            tx_timer_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Receive next state: edge detect, bit sampler, queue write and queue read
    always_comb begin
        rx_head_next  = rx_head_reg;
        rx_tail_next  = rx_tail_reg;
        rx_phase_next = rx_phase_reg;
        rx_bits_next  = rx_bits_reg;
        rx_shift_next = rx_shift_reg;
        rx_cd_next    = rx_cd_reg;
        rx_timer_next = rx_timer_reg;
        rx_last_next  = rx_last_reg;
        rx_wr         = 1'b0;
        rx_rd         = 1'b0;
        if (advance) begin
            unique case (in_reg.kind)
                KIND_TICK: begin
                    rx_last_next = in_reg.rx_level;
                    if (rx_timer_reg) begin
                        if (rx_cd_reg <= 17'd1) begin
                            rx_cd_next = {1'b0, bit_period_reg};
                            unique case (rx_phase_reg)
                                RX_DATA: begin
                                    if (in_reg.rx_level) begin
                                        rx_shift_next[rx_bits_reg[2:0]] = 1'b1;
                                    end
                                    rx_bits_next = rx_bits_reg + 4'd1;
                                    if (rx_bits_next >= BITS_DONE) begin
                                        rx_phase_next = RX_STOP;
                                    end
                                end
                                RX_STOP: begin
                                    // good stop bit and room left: keep the byte
                                    if (in_reg.rx_level && !rx_full) begin
                                        rx_wr        = 1'b1;
                                        rx_head_next = rx_head_inc;
                                    end
                                    rx_phase_next = RX_IDLE;
                                    rx_timer_next = 1'b0;
                                end
                                default: begin
                                    rx_phase_next = RX_IDLE;
                                    rx_timer_next = 1'b0;
                                end
                            endcase
                        end else begin
                            rx_cd_next = rx_cd_reg - 17'd1;
                        end
                    end else if (rx_last_reg && !in_reg.rx_level) begin
                        // start bit: first sample lands mid-way into bit 0
                        rx_phase_next = RX_DATA;
                        rx_bits_next  = '0;
                        rx_shift_next = '0;
                        rx_cd_next    = {1'b0, bit_period_reg} + 17'(bit_period_reg >> 1);
                        rx_timer_next = 1'b1;
                    end
                end
                KIND_READ: begin
                    if (!rx_empty) begin
                        rx_rd        = 1'b1;
                        rx_tail_next = rx_tail_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    // Result fields
    always_comb begin
        if (tx_head_next >= tx_tail_next) begin
            tx_count = TX_CW'(tx_head_next) - TX_CW'(tx_tail_next);
        end else begin
            tx_count = TX_CW'(tx_head_next) + TX_CW'(TX_QUEUE_DEPTH) - TX_CW'(tx_tail_next);
        end
        if (rx_head_next >= rx_tail_next) begin
            rx_count = RX_CW'(rx_head_next) - RX_CW'(rx_tail_next);
        end else begin
            rx_count = RX_CW'(rx_head_next) + RX_CW'(RX_QUEUE_DEPTH) - RX_CW'(rx_tail_next);
        end
        tx_cnt_next     = tx_count[5:0];
        rx_cnt_next     = rx_count[5:0];
        read_valid_next = rx_rd;
        write_acc_next  = tx_wr;
    end

    assign m_data = '{
        tx_level:       tx_level_reg,
        read_byte:      read_valid_reg ? rd_byte_reg : 8'd0,
        read_valid:     read_valid_reg,
        write_accepted: write_acc_reg,
        rx_count:       rx_cnt_reg,
        tx_count:       tx_cnt_reg
    };

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            bit_period_reg <= BIT_PERIOD_RESET;
            tx_head_reg    <= '0;
            tx_tail_reg    <= '0;
            tx_phase_reg   <= TX_IDLE;
            tx_bits_reg    <= '0;
            tx_cd_reg      <= '0;
            tx_timer_reg   <= 1'b0;
            tx_out_reg     <= 1'b1;
            rx_head_reg    <= '0;
            rx_tail_reg    <= '0;
            rx_phase_reg   <= RX_IDLE;
            rx_bits_reg    <= '0;
            rx_cd_reg      <= '0;
            rx_timer_reg   <= 1'b0;
            rx_last_reg    <= 1'b1;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr) begin
                bit_period_reg <= pwdata[15:0];
            end
            tx_head_reg  <= tx_head_next;
            tx_tail_reg  <= tx_tail_next;
            tx_phase_reg <= tx_phase_next;
            tx_bits_reg  <= tx_bits_next;
            tx_cd_reg    <= tx_cd_next;
            tx_timer_reg <= tx_timer_next;
            tx_out_reg   <= tx_out_next;
            rx_head_reg  <= rx_head_next;
            rx_tail_reg  <= rx_tail_next;
            rx_phase_reg <= rx_phase_next;
            rx_bits_reg  <= rx_bits_next;
            rx_cd_reg    <= rx_cd_next;
            rx_timer_reg <= rx_timer_next;
            rx_last_reg  <= rx_last_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            tx_level_reg   <= tx_out_next;
            read_valid_reg <= read_valid_next;
            write_acc_reg  <= write_acc_next;
            rx_cnt_reg     <= rx_cnt_next;
            tx_cnt_reg     <= tx_cnt_next;
        end
        rx_shift_reg <= rx_shift_next;
    end

    // Transmit queue: write at head, read at tail straight into the shifter
    always_ff @(posedge aclk) begin
        if (tx_wr) begin
            tx_mem[tx_head_reg] <= in_reg.data_byte;
        end
        if (tx_load) begin
            tx_shift_reg <= tx_mem[tx_tail_reg];
        end
    end

    // Receive queue: write at head, read at tail into the result register
    always_ff @(posedge aclk) begin
        if (rx_wr) begin
            rx_mem[rx_head_reg] <= rx_shift_reg;
        end
        if (rx_rd) begin
            rd_byte_reg <= rx_mem[rx_tail_reg];
        end
    end

endmodule

// ----- src/uart_chk.sv -----
// Port-level checker for the UART transceiver, bound to the top level.
// Depends on uart_pkg and uart_8n1_transceiver_fifo_unit.
module uart_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input uart_pkg::out_item_t m_data
);
    import uart_pkg::*;

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        aresetn && !$past(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // Input backpressure only when a result is pending and not taken
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output stall");

    // An item accepted while no result is pending yields a result through the input and result registers
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> ##1 m_valid)
        else $error("result missing after accepted item");

endmodule

bind uart_8n1_transceiver_fifo_unit uart_chk u_uart_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- test/uart_8n1_transceiver_fifo_unit_tb.sv -----
// Self-checking testbench for uart_8n1_transceiver_fifo_unit: directed table, then
// random phases at several bit periods, checked against a built-in UART predictor.
// Depends on uart_pkg and the block's RTL only.
`timescale 1ns / 1ps

module uart_8n1_transceiver_fifo_unit_tb;
    import uart_pkg::*;

    localparam logic [1:0] KIND_NOP = 2'd3;   // fourth kind: no action
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_PHASE = 1;
    localparam int QAW = $clog2(TX_QUEUE_DEPTH_DEF);
    localparam logic [PADDR_W-1:0] BIT_PERIOD_ADDR = PADDR_W'(4 * REG_BIT_PERIOD);

    typedef enum logic [1:0] {
        LINE_LOOPBACK,
        LINE_FRAMES,
        LINE_NOISE
    } line_mode_t;

    typedef struct packed {
        in_item_t  stim;
        logic      typed;
        out_item_t want;
    } step_row_t;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] count;
        line_mode_t  mode;
        logic [7:0]  rd_pct;
        logic [7:0]  wr_pct;
    } phase_t;

    // Idle result: line high, nothing read or queued
    localparam out_item_t IDLE_OUT = '{1'b1, 8'h00, 1'b0, 1'b0, 6'd0, 6'd0};
    localparam out_item_t NO_WANT = '0;

    // Directed stimulus at the reset bit period (208)
    localparam int DIR_ROWS = 19;
    localparam step_row_t DIRECTED [DIR_ROWS] = '{
        '{'{KIND_READ,  8'h00, 1'b1}, 1'b1, IDLE_OUT},                      // read while empty
        '{'{KIND_NOP,   8'hFF, 1'b0}, 1'b1, IDLE_OUT},                      // no-op kind
        '{'{KIND_TICK,  8'h00, 1'b1}, 1'b1, IDLE_OUT},
        '{'{KIND_WRITE, 8'h00, 1'b0}, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1, 6'd0, 6'd1}},
        '{'{KIND_WRITE, 8'hFF, 1'b1}, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b1, 6'd0, 6'd2}},
        '{'{KIND_TICK,  8'hFF, 1'b0}, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 6'd0, 6'd2}},
        '{'{KIND_TICK,  8'h00, 1'b1}, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 6'd0, 6'd2}},
        '{'{KIND_READ,  8'hFF, 1'b0}, 1'b1, '{1'b1, 8'h00, 1'b0, 1'b0, 6'd0, 6'd2}},
        '{'{KIND_TICK,  8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{KIND_TICK,  8'h00, 1'b1}, 1'b0, NO_WANT},
        '{'{KIND_TICK,  8'h00, 1'b1}, 1'b0, NO_WANT},
        '{'{KIND_TICK,  8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{KIND_TICK,  8'h00, 1'b1}, 1'b0, NO_WANT},
        '{'{KIND_TICK,  8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{KIND_TICK,  8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{KIND_TICK,  8'h00, 1'b1}, 1'b0, NO_WANT},                        // start bit goes out
        '{'{KIND_NOP,   8'hFF, 1'b1}, 1'b0, NO_WANT},
        '{'{KIND_WRITE, 8'hAA, 1'b1}, 1'b0, NO_WANT},
        '{'{KIND_READ,  8'h55, 1'b0}, 1'b0, NO_WANT}
    };

    // Random phases: bit period, items, receive line source, read and write share
    localparam int NUM_PHASES = 8;
    localparam phase_t PHASES [NUM_PHASES] = '{
        '{16'd1,     16'd200, LINE_LOOPBACK, 8'd8,  8'd12},
        '{16'd2,     16'd200, LINE_FRAMES,   8'd10, 8'd8},
        '{16'd0,     16'd100, LINE_FRAMES,   8'd10, 8'd10},
        '{16'd3,     16'd100, LINE_NOISE,    8'd10, 8'd10},
        '{16'd1,     16'd900, LINE_FRAMES,   8'd0,  8'd4},   // fills the receive queue
        '{16'd65535, 16'd50,  LINE_NOISE,    8'd30, 8'd20},
        '{16'd43690, 16'd30,  LINE_NOISE,    8'd20, 8'd20},
        '{16'd5,     16'd200, LINE_LOOPBACK, 8'd15, 8'd10}
    };

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_item_t            s_data;
    logic                m_valid;
    logic                m_ready;
    out_item_t           m_data;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    out_item_t pending_results[$];
    bit        line_ticks[$];
    int        fail_count = 0;
    int        result_idx = 0;
    int        idle_cycles = 0;
    int        stall_pct = 0;
    bit        hold_request = 1'b0;

    // Predictor state
    logic [15:0]    bp;
    logic [7:0]     tx_mem [TX_QUEUE_DEPTH_DEF];
    logic [QAW-1:0] tx_wr, tx_rd;
    tx_phase_t      tx_ph;
    logic [3:0]     tx_bits;
    logic [7:0]     tx_sr;
    logic [15:0]    tx_cd;
    logic           tx_run, tx_line;
    logic [7:0]     rx_mem [RX_QUEUE_DEPTH_DEF];
    logic [QAW-1:0] rx_wr, rx_rd;
    rx_phase_t      rx_ph;
    logic [3:0]     rx_bits;
    logic [7:0]     rx_sr;
    logic [16:0]    rx_cd;
    logic           rx_run, rx_prev;

    uart_8n1_transceiver_fifo_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Advance the UART predictor by one transaction and return its result.
    // Queue pointers wrap at the power-of-two depth, so counts come out mod 64.
    function automatic out_item_t uart_next_result(in_item_t it);
        out_item_t res;
        res = '0;
        case (it.kind)
            KIND_TICK: begin
                // transmit bit timer
                if (tx_run) begin
                    if (tx_cd <= 16'd1) begin
                        tx_cd = bp;
                        case (tx_ph)
                            TX_START: begin
                                if (tx_wr == tx_rd) begin
                                    tx_ph = TX_IDLE;
                                    tx_run = 1'b0;
                                end else begin
                                    tx_line = 1'b0;
                                    tx_sr = tx_mem[tx_rd];
                                    tx_rd = tx_rd + 1'b1;
                                    tx_bits = 4'd0;
                                    tx_ph = TX_DATA;
                                end
                            end
                            TX_DATA: begin
                                tx_line = tx_sr[tx_bits[2:0]];
                                tx_bits = tx_bits + 4'd1;
                                if (tx_bits >= 4'(DATA_BITS)) tx_ph = TX_STOP;
                            end
                            TX_STOP: begin
                                tx_line = 1'b1;
                                tx_ph = TX_IDLE;
                            end
                            default: begin
                                // idle bit period done: next byte or stop the timer
                                if (tx_wr != tx_rd) tx_ph = TX_START;
                                else tx_run = 1'b0;
                            end
                        endcase
                    end else begin
                        tx_cd = tx_cd - 16'd1;
                    end
                end
                // receive sampling, or start-bit edge search while the timer is off
                if (rx_run) begin
                    if (rx_cd <= 17'd1) begin
                        rx_cd = {1'b0, bp};
                        case (rx_ph)
                            RX_DATA: begin
                                if (it.rx_level) rx_sr[rx_bits[2:0]] = 1'b1;
                                rx_bits = rx_bits + 4'd1;
                                if (rx_bits >= 4'(DATA_BITS)) rx_ph = RX_STOP;
                            end
                            RX_STOP: begin
                                // good stop bit and room in the queue: keep the byte
                                if (it.rx_level && (rx_wr + 1'b1) != rx_rd) begin
                                    rx_mem[rx_wr] = rx_sr;
                                    rx_wr = rx_wr + 1'b1;
                                end
                                rx_ph = RX_IDLE;
                                rx_run = 1'b0;
                            end
                            default: begin
                                rx_ph = RX_IDLE;
                                rx_run = 1'b0;
                            end
                        endcase
                    end else begin
                        rx_cd = rx_cd - 17'd1;
                    end
                end else if (rx_prev && !it.rx_level) begin
                    rx_ph = RX_DATA;
                    rx_bits = 4'd0;
                    rx_sr = 8'h00;
                    rx_cd = 17'(({2'b00, bp} * 18'd3) >> 1);
                    rx_run = 1'b1;
                end
                rx_prev = it.rx_level;
            end
            KIND_WRITE: begin
                // full queue drops the byte
                if ((tx_wr + 1'b1) != tx_rd) begin
                    tx_mem[tx_wr] = it.data_byte;
                    tx_wr = tx_wr + 1'b1;
                    res.write_accepted = 1'b1;
                    if (tx_ph == TX_IDLE) begin
                        tx_ph = TX_START;
                        tx_cd = TX_START_DELAY;
                        tx_run = 1'b1;
                    end
                end
            end
            KIND_READ: begin
                if (rx_wr != rx_rd) begin
                    res.read_byte = rx_mem[rx_rd];
                    res.read_valid = 1'b1;
                    rx_rd = rx_rd + 1'b1;
                end
            end
            default: ;
        endcase
        res.tx_level = tx_line;
        res.rx_count = 6'(rx_wr - rx_rd);
        res.tx_count = 6'(tx_wr - tx_rd);
        return res;
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result
    task automatic offer_item(input in_item_t it, input logic typed, input out_item_t want);
        out_item_t pred;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= it;
        do @(posedge aclk); while (!s_ready);
        pred = uart_next_result(it);
        pending_results.push_back(typed ? want : pred);
    endtask

    task automatic hold_sender(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Sender pauses until every result is back and the pipeline is empty
    task automatic wait_drained();
        hold_sender(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Stimulus driver
    initial begin
        in_item_t    it;
        int          gap_pct;
        int          hold;
        int          r;
        int          rd_share;
        int          wr_share;
        int          wr_burst;
        int          rd_burst;
        logic [7:0]  frame_byte;
        logic        stop_lvl;

        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        // predictor reset
        bp = BIT_PERIOD_RESET;
        tx_wr = '0;
        tx_rd = '0;
        tx_ph = TX_IDLE;
        tx_bits = 4'd0;
        tx_sr = 8'h00;
        tx_cd = 16'd0;
        tx_run = 1'b0;
        tx_line = 1'b1;
        rx_wr = '0;
        rx_rd = '0;
        rx_ph = RX_IDLE;
        rx_bits = 4'd0;
        rx_sr = 8'h00;
        rx_cd = 17'd0;
        rx_run = 1'b0;
        rx_prev = 1'b1;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (int i = 0; i < DIR_ROWS; i++)
            offer_item(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);

        // random phases, each at its own bit period
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();

            // register write, then read back over the same select
            @(negedge aclk);
            psel <= 1'b1;
            pwrite <= 1'b1;
            paddr <= BIT_PERIOD_ADDR;
            pwdata <= {16'h0000, PHASES[p].period};
            @(negedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            bp = PHASES[p].period;
            @(negedge aclk);
            penable <= 1'b0;
            pwrite <= 1'b0;
            @(negedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            if (prdata[15:0] !== bp) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: bit_period readback want %0d got %0d",
                             $realtime, bp, prdata[15:0]);
            end
            @(negedge aclk);
            psel <= 1'b0;
            penable <= 1'b0;

            // idling levels for this phase; none in the last one
            if (p == NUM_PHASES - 1) begin
                gap_pct = 0;
                stall_pct = 0;
            end else begin
                gap_pct = $urandom_range(0, 15);
                stall_pct = $urandom_range(0, 15);
            end
            if (p == HOLD_PHASE) hold_request = 1'b1;
            rd_share = int'(PHASES[p].rd_pct);
            wr_share = int'(PHASES[p].wr_pct);
            wr_burst = 0;
            rd_burst = 0;
            line_ticks.delete();

            for (int n = 0; n < int'(PHASES[p].count); n++) begin
                if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
                    hold_sender($urandom_range(1, 19));
                it.data_byte = 8'($urandom);
                it.rx_level = 1'($urandom);

                // kind: bursts of writes or reads drive the queues to full and empty
                if (wr_burst != 0) begin
                    wr_burst--;
                    it.kind = KIND_WRITE;
                end else if (rd_burst != 0) begin
                    rd_burst--;
                    it.kind = KIND_READ;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < rd_share) it.kind = KIND_READ;
                    else if (r < rd_share + wr_share) it.kind = KIND_WRITE;
                    else if (r < rd_share + wr_share + 2) it.kind = KIND_NOP;
                    else it.kind = KIND_TICK;
                    if ($urandom_range(0, 149) == 0) wr_burst = $urandom_range(40, 80);
                    else if (rd_share != 0 && $urandom_range(0, 149) == 0)
                        rd_burst = $urandom_range(40, 80);
                end

                // receive line level for ticks
                if (it.kind == KIND_TICK) begin
                    case (PHASES[p].mode)
                        LINE_LOOPBACK: it.rx_level = tx_line;
                        LINE_FRAMES: begin
                            if (line_ticks.size() == 0) begin
                                // idle, optional glitch, start, 8 data LSB first, stop
                                hold = (bp == 16'd0) ? 1 : int'(bp);
                                repeat ($urandom_range(0, 1) * hold) line_ticks.push_back(1'b1);
                                if ($urandom_range(0, 29) == 0) begin
                                    line_ticks.push_back(1'b0);
                                    line_ticks.push_back(1'b1);
                                end
                                frame_byte = 8'($urandom);
                                stop_lvl = ($urandom_range(0, 9) != 0);
                                repeat (hold) line_ticks.push_back(1'b0);
                                for (int b = 0; b < DATA_BITS; b++)
                                    repeat (hold) line_ticks.push_back(frame_byte[b]);
                                repeat (hold) line_ticks.push_back(stop_lvl);
                                if (!stop_lvl) repeat (hold) line_ticks.push_back(1'b1);
                            end
                            it.rx_level = line_ticks.pop_front();
                        end
                        default: ;
                    endcase
                end
                offer_item(it, 1'b0, NO_WANT);
            end
        end

        wait_drained();
        if (fail_count == 0 && pending_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result receiver: random stall bursts and one long hold-off
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
                n = $urandom_range(1, 19);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin : check_results
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected result %h", $realtime, m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.tx_level !== want.tx_level || m_data.read_byte !== want.read_byte ||
                    m_data.read_valid !== want.read_valid ||
                    m_data.write_accepted !== want.write_accepted ||
                    m_data.rx_count !== want.rx_count || m_data.tx_count !== want.tx_count) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result %0d want tx=%b byte=%h rv=%b wa=%b rxc=%0d txc=%0d",
                                 $realtime, result_idx, want.tx_level, want.read_byte,
                                 want.read_valid, want.write_accepted, want.rx_count,
                                 want.tx_count,
                                 "\n    got tx=%b byte=%h rv=%b wa=%b rxc=%0d txc=%0d",
                                 m_data.tx_level, m_data.read_byte, m_data.read_valid,
                                 m_data.write_accepted, m_data.rx_count, m_data.tx_count);
                end
            end
            result_idx++;
        end
    end

    // Watchdog: too long without any transaction or register access
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
